// File: design/tbw_pkg.sv
// ----------------------------------------------------------------------------
// tbw_pkg
// Shared types, constants and helpers of the tile background/window pixel unit.
// ----------------------------------------------------------------------------
package tbw_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 144;
    localparam int RAM_DEPTH     = 8192;
    localparam int RAM_AW        = $clog2(RAM_DEPTH);

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // video ram offsets, relative to 0x8000
    localparam logic [RAM_AW-1:0] MAP0_OFF        = RAM_AW'(16'h9800 - 16'h8000);
    localparam logic [RAM_AW-1:0] MAP1_OFF        = RAM_AW'(16'h9C00 - 16'h8000);
    localparam logic [RAM_AW-1:0] SIGNED_TILE_OFF = RAM_AW'(16'h9000 - 16'h0800 - 16'h8000);

    // lcd_control bit positions
    localparam int LCDC_LCD_EN   = 7;
    localparam int LCDC_WIN_MAP  = 6;
    localparam int LCDC_WIN_EN   = 5;
    localparam int LCDC_TILE_UNS = 4;
    localparam int LCDC_BG_MAP   = 3;
    localparam int LCDC_BG_EN    = 0;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_LCD_CONTROL = 3'd0,
        REG_SCROLL_Y    = 3'd1,
        REG_SCROLL_X    = 3'd2,
        REG_WINDOW_Y    = 3'd3,
        REG_WINDOW_X    = 3'd4,
        REG_BG_PALETTE  = 3'd5
    } tbw_reg_idx_t;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_y;
        logic [7:0] scroll_x;
        logic [7:0] window_y;
        logic [7:0] window_x;
        logic [7:0] bg_palette;
    } tbw_cfg_t;

    localparam tbw_cfg_t CFG_RESET = '{
        lcd_control: 8'd145,
        scroll_y:    8'd0,
        scroll_x:    8'd0,
        window_y:    8'd0,
        window_x:    8'd0,
        bg_palette:  8'd252
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TILE,
        ST_LOW,
        ST_HIGH
    } tbw_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic rd_low;
        logic rd_high;
        logic load_out;
    } tbw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_sample;
        logic on_screen;
        logic blank;
        logic out_free;
    } tbw_status_t;

    function automatic logic [31:0] shade_argb(input logic [1:0] shade);
        logic [31:0] c;
        case (shade)
            2'd0:    c = 32'hFFE0F8D0;
            2'd1:    c = 32'hFF88C070;
            2'd2:    c = 32'hFF346856;
            default: c = 32'hFF081820;
        endcase
        return c;
    endfunction

endpackage

// File: design/tbw_regs.sv
// ----------------------------------------------------------------------------
// tbw_regs
// APB register file holding the display control, scroll, window and palette.
// ----------------------------------------------------------------------------
module tbw_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbw_pkg::PADDR_W-1:0]    paddr,
    input  logic [tbw_pkg::PDATA_W-1:0]    pwdata,
    output logic [tbw_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    output tbw_pkg::tbw_cfg_t              cfg
);
    import tbw_pkg::*;

    tbw_cfg_t   cfg_reg;
    tbw_cfg_t   cfg_next;
    logic [2:0] idx;
    logic       wr_en;
    logic [7:0] rd_byte;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LCD_CONTROL: cfg_next.lcd_control = pwdata[7:0];
                REG_SCROLL_Y:    cfg_next.scroll_y    = pwdata[7:0];
                REG_SCROLL_X:    cfg_next.scroll_x    = pwdata[7:0];
                REG_WINDOW_Y:    cfg_next.window_y    = pwdata[7:0];
                REG_WINDOW_X:    cfg_next.window_x    = pwdata[7:0];
                REG_BG_PALETTE:  cfg_next.bg_palette  = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LCD_CONTROL: rd_byte = cfg_reg.lcd_control;
            REG_SCROLL_Y:    rd_byte = cfg_reg.scroll_y;
            REG_SCROLL_X:    rd_byte = cfg_reg.scroll_x;
            REG_WINDOW_Y:    rd_byte = cfg_reg.window_y;
            REG_WINDOW_X:    rd_byte = cfg_reg.window_x;
            REG_BG_PALETTE:  rd_byte = cfg_reg.bg_palette;
            default:         rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(PDATA_W-8){1'b0}}, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/tbw_ctrl.sv
// ----------------------------------------------------------------------------
// tbw_ctrl
// Sequencer for the three dependent video ram reads of a pixel sample.
// ----------------------------------------------------------------------------
module tbw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tbw_pkg::tbw_status_t  status,
    output tbw_pkg::tbw_cmd_t     cmd
);
    import tbw_pkg::*;

    tbw_state_t state_reg;
    tbw_state_t state_next;
    logic       accept;
    tbw_state_t after_accept;

    // in the last read state the next transfer is taken as the result leaves
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_HIGH: s_tready = status.out_free;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        if (!status.is_sample || !status.on_screen)
        begin
            after_accept = ST_IDLE;
        end
        else if (status.blank)
        begin
            after_accept = ST_HIGH;
        end
        else
        begin
            after_accept = ST_TILE;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = after_accept;
                end
            end
            ST_TILE: state_next = ST_LOW;
            ST_LOW:  state_next = ST_HIGH;
            ST_HIGH:
            begin
                if (accept)
                begin
                    state_next = after_accept;
                end
                else if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_TILE: cmd.rd_low   = 1'b1;
            ST_LOW:  cmd.rd_high  = 1'b1;
            ST_HIGH: cmd.load_out = status.out_free;
            default: cmd.rd_low   = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/tbw_dp.sv
// ----------------------------------------------------------------------------
// tbw_dp
// Video ram, map and tile addressing, pixel decode and the output register.
// ----------------------------------------------------------------------------
module tbw_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbw_pkg::tbw_cfg_t             cfg,
    input  logic [tbw_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  tbw_pkg::tbw_cmd_t             cmd,
    output tbw_pkg::tbw_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tbw_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import tbw_pkg::*;

    logic [7:0]        ram_mem [RAM_DEPTH];
    logic [7:0]        rdata_reg;

    logic [RAM_AW-1:0] in_offset;
    logic [7:0]        in_byte;
    logic [7:0]        px;
    logic [7:0]        py;

    logic              win;
    logic [7:0]        map_x;
    logic [7:0]        map_y;
    logic [RAM_AW-1:0] map_addr;
    logic [RAM_AW-1:0] tile_base;
    logic [RAM_AW-1:0] row_addr;
    logic [RAM_AW-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;

    logic [2:0]        mx_reg;
    logic [2:0]        my_reg;
    logic              win_reg;
    logic              blank_reg;
    logic [RAM_AW-1:0] row_reg;
    logic [7:0]        low_reg;

    logic [1:0]        cidx;
    logic [1:0]        shade;
    logic [2:0]        bit_sel;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_cidx_reg;
    logic [1:0]        out_shade_reg;
    logic [31:0]       out_argb_reg;
    logic              out_win_reg;

    assign in_offset = s_tdata[12:0];
    assign in_byte   = s_tdata[20:13];
    assign px        = s_tdata[28:21];
    assign py        = s_tdata[36:29];

    // window test and map coordinates
    always_comb
    begin
        win = cfg.lcd_control[LCDC_WIN_EN] && (py >= cfg.window_y)
              && ({1'b0, px} + 9'd7 >= {1'b0, cfg.window_x});
        if (win)
        begin
            map_x = px + 8'd7 - cfg.window_x;
            map_y = py - cfg.window_y;
        end
        else
        begin
            map_x = px + cfg.scroll_x;
            map_y = py + cfg.scroll_y;
        end
    end

    always_comb
    begin
        logic sel;
        sel = win ? cfg.lcd_control[LCDC_WIN_MAP] : cfg.lcd_control[LCDC_BG_MAP];
        map_addr = (sel ? MAP1_OFF : MAP0_OFF) + {3'b000, map_y[7:3], map_x[7:3]};
    end

    // rdata holds the tile index during the tile state
    always_comb
    begin
        if (cfg.lcd_control[LCDC_TILE_UNS])
        begin
            tile_base = {1'b0, rdata_reg, 4'b0000};
        end
        else
        begin
            tile_base = SIGNED_TILE_OFF + {1'b0, rdata_reg ^ 8'h80, 4'b0000};
        end
        row_addr = tile_base + {{(RAM_AW-4){1'b0}}, my_reg, 1'b0};
    end

    always_comb
    begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = row_addr;
        if (cmd.accept)
        begin
            if (s_tuser == OP_WRITE)
            begin
                ram_we   = 1'b1;
                ram_addr = in_offset;
            end
            else
            begin
                ram_re   = 1'b1;
                ram_addr = map_addr;
            end
        end
        else if (cmd.rd_low)
        begin
            ram_re   = 1'b1;
            ram_addr = row_addr;
        end
        else if (cmd.rd_high)
        begin
            ram_re   = 1'b1;
            ram_addr = {row_reg[RAM_AW-1:1], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_addr] <= in_byte;
        end
        if (ram_re)
        begin
            rdata_reg <= ram_mem[ram_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mx_reg    <= map_x[2:0];
            my_reg    <= map_y[2:0];
            win_reg   <= win;
            blank_reg <= status.blank;
        end
        if (cmd.rd_low)
        begin
            row_reg <= row_addr;
        end
        if (cmd.rd_high)
        begin
            low_reg <= rdata_reg;
        end
    end

    // rdata holds the high plane in the last read state; bit 7 is the leftmost pixel
    assign bit_sel = ~mx_reg;

    always_comb
    begin
        if (blank_reg)
        begin
            cidx = 2'd0;
        end
        else
        begin
            cidx = {rdata_reg[bit_sel], low_reg[bit_sel]};
        end
        case (cidx)
            2'd0:    shade = cfg.bg_palette[1:0];
            2'd1:    shade = cfg.bg_palette[3:2];
            2'd2:    shade = cfg.bg_palette[5:4];
            default: shade = cfg.bg_palette[7:6];
        endcase
        if (blank_reg)
        begin
            shade = 2'd0;
        end
    end

    assign status.is_sample = (s_tuser == OP_SAMPLE);
    assign status.on_screen = ({1'b0, px} < 9'(SCREEN_WIDTH))
                              && ({1'b0, py} < 9'(SCREEN_HEIGHT));
    assign status.blank     = !cfg.lcd_control[LCDC_LCD_EN] || !cfg.lcd_control[LCDC_BG_EN];
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_cidx_reg  <= cidx;
            out_shade_reg <= shade;
            out_argb_reg  <= shade_argb(shade);
            out_win_reg   <= win_reg && !blank_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-36){1'b0}}, out_argb_reg, out_shade_reg, out_cidx_reg};
    assign m_tuser  = out_win_reg;

endmodule

// File: design/tile_background_window_pixel_unit.sv
// ----------------------------------------------------------------------------
// tile_background_window_pixel_unit
// Background/window pixel sampler with an 8 KiB video ram filled by writes.
//
//  port group   dir  payload
//  s_*          in   tuser: opcode; tdata: ram_offset, ram_byte, pixel_x, pixel_y
//  m_*          out  tuser: from_window; tdata: color_index, shade, pixel_argb
//  apb          in   six 8-bit registers at byte addresses 0x00..0x14
//
// a write transfer goes straight to the video ram, and writes can follow back to back; a sample
// makes three video ram reads in order (tile index, low plane, high plane) on the single ram port.
// blanked samples go straight to the result; off-screen ones give no result.
// the result sits in an output register; the next transfer is taken in the
// cycle it is loaded unless that register is still stalled.
// reset clears the sequencer and output valid and loads the registers with their reset values; ram is not cleared.
// ----------------------------------------------------------------------------
module tile_background_window_pixel_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [12:0] ram_offset, [20:13] ram_byte, [28:21] pixel_x, [36:29] pixel_y
    input  logic [tbw_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] color_index, [3:2] shade, [35:4] pixel_argb
    output logic [tbw_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] from_window
    output logic                          m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tbw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tbw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tbw_pkg::*;

    tbw_cfg_t    cfg;
    tbw_cmd_t    cmd;
    tbw_status_t status;

    tbw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbw_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
